FILE: rtl/core/efbt_pkg.sv
// shared types and constants for the expiring fuzzy bin table
// no dependencies

package efbt_pkg;

   localparam int BIN_W  = 16;
   localparam int TIME_W = 32;
   localparam int TTL_W  = 16;
   localparam int DB_W   = 8;
   localparam int CNT_W  = 32;
   localparam int CSR_IDX_W = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_DEADBAND = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MATCH_EN = 4'd1;

   localparam logic [DB_W-1:0] DEADBAND_RESET = 8'd2;
   localparam logic [TIME_W-1:0] EXPIRY_MAX = 32'hFFFF_FFFF;

   typedef enum logic [1:0] {
      ACT_PUBLISH   = 2'd0,
      ACT_CLEAR     = 2'd1,
      ACT_CLEAR_ALL = 2'd2,
      ACT_MATCH     = 2'd3
   } action_type;

   typedef struct packed {
      logic [BIN_W-1:0]  bin;
      logic [TIME_W-1:0] expiry;
   } entry_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic kill_one;
      logic kill_all;
   } tbl_ctl_type;

   typedef struct packed {
      logic hit;
      logic pub_inc;
      logic clr_inc;
   } result_type;

endpackage

FILE: rtl/core/efbt_table.sv
// entry memory with one synchronous read port and one write port
// per-entry valid bits make never-written and killed entries read as zero; uses efbt_pkg

module efbt_table import efbt_pkg::*; #(
   parameter int ENTRIES = 8,
   parameter int IW = 3
) (
   input  logic              clock,
   input  logic              reset,
   input  tbl_ctl_type       ctl,
   input  logic [IW-1:0]     rd_addr,
   input  logic [IW-1:0]     wr_addr,
   input  entry_type         wr_entry,
   output entry_type         rd_entry
);

   entry_type            mem [ENTRIES];
   logic [ENTRIES-1:0]   valid_ff;
   logic [ENTRIES-1:0]   valid_in;
   entry_type            rd_data_ff;
   logic                 rd_valid_ff;

   always_comb begin
      valid_in = valid_ff;
      if (ctl.kill_all) begin
         valid_in = '0;
      end else if (ctl.wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end else if (ctl.kill_one) begin
         valid_in[wr_addr] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_data_ff  <= mem[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_entry = rd_valid_ff ? rd_data_ff : '0;

endmodule

FILE: rtl/core/efbt_ctrl.sv
// operation sequencer: scans the entry memory one slot per cycle (clear all skips
// it), then writes back; uses efbt_pkg, drives efbt_table through a control struct

module efbt_ctrl import efbt_pkg::*; #(
   parameter int ENTRIES = 8,
   parameter int IW = 3,
   parameter int CW = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_action,
   input  logic [BIN_W-1:0]   req_bin,
   input  logic [TIME_W-1:0]  req_now,
   input  logic [TTL_W-1:0]   req_ttl,
   input  logic [DB_W-1:0]    deadband,
   input  logic               match_en,
   output tbl_ctl_type        ctl,
   output logic [IW-1:0]      rd_addr,
   output logic [IW-1:0]      wr_addr,
   output entry_type          wr_entry,
   input  entry_type          rd_entry,
   output logic               done_valid,
   input  logic               done_ready,
   output result_type         result
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_WRITE = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   state_type            state_ff, state_in;
   action_type           action_ff, action_in;
   logic [BIN_W-1:0]     bin_ff, bin_in;
   logic [TIME_W-1:0]    now_ff, now_in;
   logic [TIME_W-1:0]    deadline_ff, deadline_in;
   logic [CW-1:0]        issue_cnt_ff, issue_cnt_in;
   logic                 rd_vld_ff, rd_vld_in;
   logic [IW-1:0]        rd_idx_ff, rd_idx_in;
   logic                 match_found_ff, match_found_in;
   logic [IW-1:0]        match_idx_ff, match_idx_in;
   logic                 free_found_ff, free_found_in;
   logic [IW-1:0]        free_idx_ff, free_idx_in;
   logic [TIME_W-1:0]    soon_exp_ff, soon_exp_in;
   logic [IW-1:0]        soon_idx_ff, soon_idx_in;
   result_type           result_ff, result_in;

   logic                 live;
   logic                 close;
   logic [BIN_W-1:0]     diff;

   assign req_ready  = (state_ff == ST_IDLE);
   assign done_valid = (state_ff == ST_DONE);
   assign result     = result_ff;
   assign rd_addr    = issue_cnt_ff[IW-1:0];

   always_comb begin
      live  = (rd_entry.expiry != '0) && (now_ff < rd_entry.expiry);
      diff  = (rd_entry.bin >= bin_ff) ? (rd_entry.bin - bin_ff) : (bin_ff - rd_entry.bin);
      close = (diff <= {{(BIN_W-DB_W){1'b0}}, deadband});
   end

   always_comb begin
      state_in       = state_ff;
      action_in      = action_ff;
      bin_in         = bin_ff;
      now_in         = now_ff;
      deadline_in    = deadline_ff;
      issue_cnt_in   = issue_cnt_ff;
      rd_idx_in      = rd_addr;
      match_found_in = match_found_ff;
      match_idx_in   = match_idx_ff;
      free_found_in  = free_found_ff;
      free_idx_in    = free_idx_ff;
      soon_exp_in    = soon_exp_ff;
      soon_idx_in    = soon_idx_ff;
      result_in      = result_ff;
      ctl            = '0;
      wr_addr        = match_idx_ff;
      wr_entry.bin    = bin_ff;
      wr_entry.expiry = deadline_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               action_in      = action_type'(req_action);
               bin_in         = req_bin;
               now_in         = req_now;
               deadline_in    = req_now + {{(TIME_W-TTL_W){1'b0}}, req_ttl};
               issue_cnt_in   = '0;
               match_found_in = 1'b0;
               match_idx_in   = '0;
               free_found_in  = 1'b0;
               free_idx_in    = '0;
               soon_exp_in    = EXPIRY_MAX;
               soon_idx_in    = '0;
               result_in      = '0;
               state_in = (action_type'(req_action) == ACT_CLEAR_ALL) ? ST_WRITE : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (issue_cnt_ff < CW'(ENTRIES)) begin
               ctl.rd_en    = 1'b1;
               issue_cnt_in = issue_cnt_ff + CW'(1);
            end
            if (rd_vld_ff) begin
               if (live && close && !match_found_ff) begin
                  match_found_in = 1'b1;
                  match_idx_in   = rd_idx_ff;
               end
               if (!live && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in   = rd_idx_ff;
               end
               if (rd_entry.expiry < soon_exp_ff) begin
                  soon_exp_in = rd_entry.expiry;
                  soon_idx_in = rd_idx_ff;
               end
               if (rd_idx_ff == IW'(ENTRIES - 1)) begin
                  state_in = ST_WRITE;
               end
            end
         end
         ST_WRITE: begin
            case (action_ff)
               ACT_PUBLISH: begin
                  ctl.wr_en = 1'b1;
                  if (match_found_ff) begin
                     wr_addr = match_idx_ff;
                  end else if (free_found_ff) begin
                     wr_addr = free_idx_ff;
                  end else begin
                     wr_addr = soon_idx_ff;
                  end
                  result_in.pub_inc = 1'b1;
               end
               ACT_CLEAR: begin
                  ctl.kill_one      = match_found_ff;
                  result_in.clr_inc = match_found_ff;
               end
               ACT_CLEAR_ALL: begin
                  ctl.kill_all = 1'b1;
               end
               ACT_MATCH: begin
                  result_in.hit = match_found_ff && match_en;
               end
               default: begin
                  result_in = '0;
               end
            endcase
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (done_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rd_vld_in = ctl.rd_en;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         rd_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rd_vld_ff <= rd_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff      <= action_in;
      bin_ff         <= bin_in;
      now_ff         <= now_in;
      deadline_ff    <= deadline_in;
      issue_cnt_ff   <= issue_cnt_in;
      rd_idx_ff      <= rd_idx_in;
      match_found_ff <= match_found_in;
      match_idx_ff   <= match_idx_in;
      free_found_ff  <= free_found_in;
      free_idx_ff    <= free_idx_in;
      soon_exp_ff    <= soon_exp_in;
      soon_idx_ff    <= soon_idx_in;
      result_ff      <= result_in;
   end

endmodule

FILE: rtl/core/expiring_fuzzy_bin_table.sv
// top level of the expiring fuzzy bin table: stream ports, registers, counters
// uses efbt_pkg, efbt_ctrl and efbt_table

// A table of ENTRIES slots, each a bin number with an expiry time, kept in a
// synchronous memory. Every request transaction (publish, clear one, clear
// all, match query) produces exactly one response transaction carrying the
// hit flag and both wrapping counters as they stand after the operation.
// Publish, clear one and match scan the memory one slot per cycle, and a
// request holds the block until its response is moved to the output
// register; only then is the next request accepted. Clear all skips the
// scan, since the slots are emptied through per-slot valid flags and no
// clearing pass runs after reset. A finished response sits in an output
// register, and a stalled response holds the next finished operation back.
// Register writes on the csr port are always accepted; write them only while
// the block is idle.

module expiring_fuzzy_bin_table import efbt_pkg::*; #(
   parameter int ENTRIES = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [63:0]           req_tdata,   // bin[15:0], now_ms[47:16], ttl_ms[63:48]
   input  logic [1:0]            req_tuser,   // action[1:0]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [71:0]           rsp_tdata,   // hit[0], publish_count[32:1], clear_count[64:33]
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [DB_W-1:0]       csr_wdata
);

   localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CW = $clog2(ENTRIES + 1);

   logic [DB_W-1:0]   deadband_ff, deadband_in;
   logic              match_en_ff, match_en_in;
   logic [CNT_W-1:0]  pub_cnt_ff, pub_cnt_in;
   logic [CNT_W-1:0]  clr_cnt_ff, clr_cnt_in;
   logic              hit_ff, hit_in;
   logic              rsp_valid_ff, rsp_valid_in;

   tbl_ctl_type       ctl;
   logic [IW-1:0]     rd_addr;
   logic [IW-1:0]     wr_addr;
   entry_type         wr_entry;
   entry_type         rd_entry;
   logic              done_valid;
   logic              done_ready;
   result_type        result;

   assign csr_ready  = 1'b1;
   assign done_ready = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, clr_cnt_ff, pub_cnt_ff, hit_ff};

   efbt_ctrl #(
      .ENTRIES (ENTRIES),
      .IW      (IW),
      .CW      (CW)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_action (req_tuser),
      .req_bin    (req_tdata[15:0]),
      .req_now    (req_tdata[47:16]),
      .req_ttl    (req_tdata[63:48]),
      .deadband   (deadband_ff),
      .match_en   (match_en_ff),
      .ctl        (ctl),
      .rd_addr    (rd_addr),
      .wr_addr    (wr_addr),
      .wr_entry   (wr_entry),
      .rd_entry   (rd_entry),
      .done_valid (done_valid),
      .done_ready (done_ready),
      .result     (result)
   );

   efbt_table #(
      .ENTRIES (ENTRIES),
      .IW      (IW)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .rd_addr  (rd_addr),
      .wr_addr  (wr_addr),
      .wr_entry (wr_entry),
      .rd_entry (rd_entry)
   );

   always_comb begin
      deadband_in  = deadband_ff;
      match_en_in  = match_en_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_DEADBAND: deadband_in = csr_wdata;
            CSR_MATCH_EN: match_en_in = csr_wdata[0];
            default: begin
               deadband_in = deadband_ff;
            end
         endcase
      end

      pub_cnt_in   = pub_cnt_ff;
      clr_cnt_in   = clr_cnt_ff;
      hit_in       = hit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (done_valid && done_ready) begin
         pub_cnt_in   = pub_cnt_ff + CNT_W'(result.pub_inc);
         clr_cnt_in   = clr_cnt_ff + CNT_W'(result.clr_inc);
         hit_in       = result.hit;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         deadband_ff  <= DEADBAND_RESET;
         match_en_ff  <= 1'b1;
         pub_cnt_ff   <= '0;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         deadband_ff  <= deadband_in;
         match_en_ff  <= match_en_in;
         pub_cnt_ff   <= pub_cnt_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hit_ff <= hit_in;
   end

endmodule
